>>> rtl/lru_sac_pkg.sv
`default_nettype none

package lru_sac_pkg;

    // geometry of the tag store
    localparam int NUM_SETS   = 64;
    localparam int MAX_WAYS   = 8;

    // index bits: log2 of the largest power of two not above the set count
    localparam int SET_W      = $clog2(NUM_SETS + 1) - 1;
    localparam int IDX_W      = (SET_W > 0) ? SET_W : 1;
    localparam int SET_MASK   = (1 << SET_W) - 1;
    localparam int REC_W      = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int WAY_W      = REC_W;
    localparam int CNT_W      = $clog2(MAX_WAYS + 1);

    // field widths
    localparam int ADDR_W     = 32;
    localparam int OWNER_W    = 4;
    localparam int BSL_W      = 4;
    localparam int WAYS_W     = 4;
    localparam int LAT_W      = 10;
    localparam int WORD_SHIFT = 2;

    // configuration port
    localparam int PADDR_W    = 4;
    localparam int PDATA_W    = 32;
    localparam logic [1:0] REG_BLOCK_SIZE_LOG2 = 2'd0;
    localparam logic [1:0] REG_WAYS_IN_USE     = 2'd1;
    localparam logic [1:0] REG_MISS_LATENCY    = 2'd2;

    localparam logic [BSL_W-1:0]  BSL_RESET  = BSL_W'(6);
    localparam logic [WAYS_W-1:0] WAYS_RESET = WAYS_W'(8);
    localparam logic [LAT_W-1:0]  MISS_RESET = LAT_W'(20);

    // one way of a set row
    typedef struct packed {
        logic [ADDR_W-1:0]  addr;
        logic [OWNER_W-1:0] owner;
        logic [REC_W-1:0]   recency;
    } entry_t;

    typedef entry_t [MAX_WAYS-1:0] row_t;

endpackage

`default_nettype wire

>>> rtl/lru_set_assoc_cache_tags.sv
`default_nettype none

// Tag store for a set-associative cache shared by data loads and instruction
// fetches, with least-recently-used replacement. Each accepted item gives one
// result: hit, the access latency (1 on a hit, miss_latency on a miss) and
// whether the oldest entry of a full set was evicted. The block takes one item
// per clock unless a result waiting on out_ready stalls it. The set row and
// its valid bits are read from set memories with one read and one write port
// into the lookup stage as the item is accepted, then compared, aged and
// written back while the result register is loaded. A row written back in the
// same cycle that the next item reads it is forwarded. A flag per set, cleared
// by reset, marks the sets never written so that they read as empty, so the
// block is ready right after reset. Configuration registers sit at byte
// addresses 0 (block_size_log2), 4 (ways_in_use) and 8 (miss_latency); the
// user must ensure they are written only while idle; the block does not check.
module lru_set_assoc_cache_tags
    import lru_sac_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,

    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [PADDR_W-1:0]   paddr,
    input  wire logic [PDATA_W-1:0]   pwdata,
    output      logic [PDATA_W-1:0]   prdata,
    output      logic                 pready,

    input  wire logic                 in_valid,
    output      logic                 in_ready,
    input  wire logic [ADDR_W-1:0]    access_address,
    input  wire logic [OWNER_W-1:0]   owner_id,
    input  wire logic                 is_fetch,

    output      logic                 out_valid,
    input  wire logic                 out_ready,
    output      logic                 hit,
    output      logic [LAT_W-1:0]     access_latency,
    output      logic                 evicted
);

    // configuration registers
    logic [BSL_W-1:0]  bsl_reg;
    logic [WAYS_W-1:0] ways_reg;
    logic [LAT_W-1:0]  miss_reg;
    logic              cfg_wr;

    // set memory, valid bit memory and per-set written flags
    row_t                mem [NUM_SETS];
    logic [MAX_WAYS-1:0] valid_mem [NUM_SETS];
    logic [NUM_SETS-1:0] set_used_reg;

    // lookup stage
    logic               s1_valid_reg;
    logic [ADDR_W-1:0]  s1_addr_reg;
    logic [OWNER_W-1:0] s1_owner_reg;
    logic [IDX_W-1:0]   s1_idx_reg;
    row_t               row_reg;
    logic [MAX_WAYS-1:0] valid_row_reg;

    // result register
    logic               out_valid_reg;
    logic               hit_reg;
    logic [LAT_W-1:0]   lat_reg;
    logic               evicted_reg;

    logic               in_accept;
    logic               s1_adv;
    logic [BSL_W-1:0]   shift;
    logic [ADDR_W-1:0]  shifted;
    logic [IDX_W-1:0]   in_idx;

    logic [MAX_WAYS-1:0] valid_row;
    logic [MAX_WAYS-1:0] match;
    logic               hit_any;
    logic [REC_W-1:0]   hit_age;
    logic [CNT_W-1:0]   count;
    logic [CNT_W-1:0]   ways_eff;
    logic               free_found;
    logic [WAY_W-1:0]   free_way;
    logic [WAY_W-1:0]   old_way;
    logic [REC_W-1:0]   old_age;
    logic               do_evict;
    logic [WAY_W-1:0]   slot;
    row_t               new_row;
    logic [MAX_WAYS-1:0] new_valid;

    // handshakes
    assign pready    = 1'b1;
    assign cfg_wr    = psel & penable & pwrite;
    assign s1_adv    = s1_valid_reg & (~out_valid_reg | out_ready);
    assign in_ready  = ~s1_valid_reg | s1_adv;
    assign in_accept = in_valid & in_ready;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bsl_reg  <= BSL_RESET;
            ways_reg <= WAYS_RESET;
            miss_reg <= MISS_RESET;
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                REG_BLOCK_SIZE_LOG2: bsl_reg  <= pwdata[BSL_W-1:0];
                REG_WAYS_IN_USE:     ways_reg <= pwdata[WAYS_W-1:0];
                REG_MISS_LATENCY:    miss_reg <= pwdata[LAT_W-1:0];
                default:             ;
            endcase
        end
    end

    // configuration reads
    always_comb
    begin
        case (paddr[3:2])
            REG_BLOCK_SIZE_LOG2: prdata = PDATA_W'(bsl_reg);
            REG_WAYS_IN_USE:     prdata = PDATA_W'(ways_reg);
            REG_MISS_LATENCY:    prdata = PDATA_W'(miss_reg);
            default:             prdata = '0;
        endcase
    end

    // set index of the incoming item
    always_comb
    begin
        if (is_fetch)
            shift = (bsl_reg >= BSL_W'(WORD_SHIFT)) ? bsl_reg - BSL_W'(WORD_SHIFT) : '0;
        else
            shift = bsl_reg;
        shifted = access_address >> shift;
        in_idx  = shifted[IDX_W-1:0] & IDX_W'(SET_MASK);
    end

    // compare, find free and oldest way, build the updated row
    always_comb
    begin
        valid_row  = valid_row_reg;
        hit_age    = '0;
        count      = '0;
        free_found = 1'b0;
        free_way   = '0;
        old_way    = '0;
        for (int w = 0; w < MAX_WAYS; w++)
        begin
            match[w] = valid_row[w] && (row_reg[w].addr == s1_addr_reg)
                       && (row_reg[w].owner == s1_owner_reg);
            if (match[w])
                hit_age = row_reg[w].recency;
            count = count + CNT_W'(valid_row[w]);
        end
        hit_any = |match;

        // lowest invalid way
        for (int w = MAX_WAYS - 1; w >= 0; w--)
        begin
            if (!valid_row[w])
            begin
                free_found = 1'b1;
                free_way   = WAY_W'(w);
            end
        end

        // valid ages are distinct 0..count-1, so the oldest holds count-1
        old_age = REC_W'(count - CNT_W'(1));
        for (int w = 0; w < MAX_WAYS; w++)
        begin
            if (valid_row[w] && row_reg[w].recency == old_age)
                old_way = WAY_W'(w);
        end

        // effective associativity
        if (ways_reg == '0)
            ways_eff = CNT_W'(1);
        else if (int'(ways_reg) > MAX_WAYS)
            ways_eff = CNT_W'(MAX_WAYS);
        else
            ways_eff = CNT_W'(ways_reg);

        do_evict = ~hit_any & (count >= ways_eff);
        if (do_evict && (!free_found || old_way < free_way))
            slot = old_way;
        else
            slot = free_way;

        // aging and insertion
        new_row   = row_reg;
        new_valid = valid_row;
        if (hit_any)
        begin
            for (int w = 0; w < MAX_WAYS; w++)
            begin
                if (match[w])
                    new_row[w].recency = '0;
                else if (valid_row[w] && row_reg[w].recency < hit_age)
                    new_row[w].recency = row_reg[w].recency + REC_W'(1);
            end
        end
        else
        begin
            if (do_evict)
                new_valid[old_way] = 1'b0;
            for (int w = 0; w < MAX_WAYS; w++)
            begin
                if (new_valid[w])
                    new_row[w].recency = row_reg[w].recency + REC_W'(1);
            end
            new_valid[slot]     = 1'b1;
            new_row[slot].addr  = s1_addr_reg;
            new_row[slot].owner = s1_owner_reg;
            new_row[slot].recency = '0;
        end
    end

    // set memories: write back and read with forwarding
    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            mem[s1_idx_reg]       <= new_row;
            valid_mem[s1_idx_reg] <= new_valid;
        end
        if (in_accept)
        begin
            if (s1_adv && s1_idx_reg == in_idx)
            begin
                row_reg       <= new_row;
                valid_row_reg <= new_valid;
            end
            else
            begin
                row_reg       <= mem[in_idx];
                valid_row_reg <= set_used_reg[in_idx] ? valid_mem[in_idx] : '0;
            end
        end
    end

    // sets written since reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            set_used_reg <= '0;
        else if (s1_adv)
            set_used_reg[s1_idx_reg] <= 1'b1;
    end

    // lookup stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_accept)
            s1_valid_reg <= 1'b1;
        else if (s1_adv)
            s1_valid_reg <= 1'b0;
    end

    // lookup stage payload
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_addr_reg  <= access_address;
            s1_owner_reg <= owner_id;
            s1_idx_reg   <= in_idx;
        end
    end

    // result register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s1_adv)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    // result register payload
    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            hit_reg     <= hit_any;
            lat_reg     <= hit_any ? LAT_W'(1) : miss_reg;
            evicted_reg <= do_evict;
        end
    end

    assign out_valid      = out_valid_reg;
    assign hit            = hit_reg;
    assign access_latency = lat_reg;
    assign evicted        = evicted_reg;

endmodule

`default_nettype wire

>>> test/lru_tags_checker.sv
module lru_tags_checker
    import lru_sac_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,

    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [PADDR_W-1:0]   paddr,
    input  wire logic [PDATA_W-1:0]   pwdata,
    input  wire logic                 pready,

    input  wire logic                 in_valid,
    input  wire logic                 in_ready,
    input  wire logic [ADDR_W-1:0]    access_address,
    input  wire logic [OWNER_W-1:0]   owner_id,
    input  wire logic                 is_fetch,

    input  wire logic                 out_valid,
    input  wire logic                 out_ready,
    input  wire logic                 hit,
    input  wire logic [LAT_W-1:0]     access_latency,
    input  wire logic                 evicted,

    output int                        fail_count,
    output int                        pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic             hit;
        logic [LAT_W-1:0] latency;
        logic             evicted;
    } lookup_t;

    // shadow copy of the tag store, set-major
    logic [ADDR_W-1:0]  tag_addr  [NUM_SETS][MAX_WAYS];
    logic [OWNER_W-1:0] tag_owner [NUM_SETS][MAX_WAYS];
    logic               tag_valid [NUM_SETS][MAX_WAYS];
    logic [REC_W-1:0]   tag_age   [NUM_SETS][MAX_WAYS];

    // shadow copy of the registers
    logic [BSL_W-1:0]   block_shift;
    logic [WAYS_W-1:0]  ways_limit;
    logic [LAT_W-1:0]   miss_cycles;

    lookup_t            predicted_lookups [$];
    int                 results_seen;

    task automatic report_mismatch(input string what, input int want_val, input int got_val);
        $display("%0t ns: result %0d: %s (expected %0d, got %0d)",
                 $time, results_seen, what, want_val, got_val);
        fail_count++;
    endtask

    // one lookup: updates the shadow store and returns what the block must report
    task automatic lookup_tags(input logic [ADDR_W-1:0] addr, input logic [OWNER_W-1:0] owner,
                               input logic fetch, output lookup_t res);
        int shift;
        int set_idx;
        int ways;
        int count;
        int hit_way;
        int free_way;
        int old_way;
        int w;
        logic [REC_W-1:0] hit_age;

        // fetch indexes by word address, two bits less of shift
        if (fetch)
            shift = (block_shift >= WORD_SHIFT) ? int'(block_shift) - WORD_SHIFT : 0;
        else
            shift = int'(block_shift);
        set_idx = int'((addr >> shift) & SET_MASK);

        // associativity clamped to what the store holds
        ways = int'(ways_limit);
        if (ways < 1)
            ways = 1;
        if (ways > MAX_WAYS)
            ways = MAX_WAYS;

        count = 0;
        hit_way = -1;
        free_way = -1;
        old_way = -1;
        for (w = 0; w < MAX_WAYS; w++)
        begin
            if (tag_valid[set_idx][w])
            begin
                count++;
                if (tag_addr[set_idx][w] == addr && tag_owner[set_idx][w] == owner)
                    hit_way = w;
                if (old_way < 0 || tag_age[set_idx][w] > tag_age[set_idx][old_way])
                    old_way = w;
            end
            else if (free_way < 0)
            begin
                free_way = w;
            end
        end

        if (hit_way >= 0)
        begin
            // hit: younger entries age by one, the hit entry becomes most recent
            hit_age = tag_age[set_idx][hit_way];
            for (w = 0; w < MAX_WAYS; w++)
                if (tag_valid[set_idx][w] && tag_age[set_idx][w] < hit_age)
                    tag_age[set_idx][w]++;
            tag_age[set_idx][hit_way] = '0;
            res.hit = 1'b1;
            res.latency = LAT_W'(1);
            res.evicted = 1'b0;
        end
        else
        begin
            // miss: on a full set drop the oldest; reuse the lowest free slot
            res.evicted = 1'b0;
            if (count >= ways || free_way < 0)
            begin
                tag_valid[set_idx][old_way] = 1'b0;
                res.evicted = 1'b1;
                if (free_way < 0 || old_way < free_way)
                    free_way = old_way;
            end
            for (w = 0; w < MAX_WAYS; w++)
                if (tag_valid[set_idx][w])
                    tag_age[set_idx][w]++;
            tag_valid[set_idx][free_way] = 1'b1;
            tag_addr[set_idx][free_way] = addr;
            tag_owner[set_idx][free_way] = owner;
            tag_age[set_idx][free_way] = '0;
            res.hit = 1'b0;
            res.latency = miss_cycles;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        lookup_t want;
        int s;
        int w;

        if (!rst_n)
        begin
            for (s = 0; s < NUM_SETS; s++)
                for (w = 0; w < MAX_WAYS; w++)
                begin
                    tag_valid[s][w] = 1'b0;
                    tag_age[s][w] = '0;
                    tag_addr[s][w] = '0;
                    tag_owner[s][w] = '0;
                end
            block_shift = BSL_RESET;
            ways_limit = WAYS_RESET;
            miss_cycles = MISS_RESET;
            predicted_lookups.delete();
            fail_count = 0;
            results_seen = 0;
        end
        else
        begin
            // result side: compare with the oldest prediction
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (predicted_lookups.size() == 0)
                begin
                    report_mismatch("result with no access waiting", 0, 1);
                end
                else
                begin
                    want = predicted_lookups[0];
                    predicted_lookups.delete(0);
                    if (hit !== want.hit)
                        report_mismatch("hit", int'(want.hit), int'(hit));
                    if (access_latency !== want.latency)
                        report_mismatch("access_latency", int'(want.latency),
                                        int'(access_latency));
                    if (evicted !== want.evicted)
                        report_mismatch("evicted", int'(want.evicted), int'(evicted));
                end
            end

            // register writes
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[PADDR_W-1:2])
                    REG_BLOCK_SIZE_LOG2: block_shift = pwdata[BSL_W-1:0];
                    REG_WAYS_IN_USE:     ways_limit = pwdata[WAYS_W-1:0];
                    REG_MISS_LATENCY:    miss_cycles = pwdata[LAT_W-1:0];
                    default: ;
                endcase
            end

            // access side: predict the result of each accepted item
            if (in_valid && in_ready)
            begin
                lookup_tags(access_address, owner_id, is_fetch, want);
                predicted_lookups.insert(predicted_lookups.size(), want);
            end
        end
        pending = predicted_lookups.size();
    end

endmodule

>>> test/tb_lru_set_assoc_cache_tags.sv
module tb_lru_set_assoc_cache_tags
    import lru_sac_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400_000;
    localparam int POOL_SIZE   = 32;

    logic                 clk;
    logic                 rst_n;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [PADDR_W-1:0]   paddr;
    logic [PDATA_W-1:0]   pwdata;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;
    logic                 in_valid;
    logic                 in_ready;
    logic [ADDR_W-1:0]    access_address;
    logic [OWNER_W-1:0]   owner_id;
    logic                 is_fetch;
    logic                 out_valid;
    logic                 out_ready;
    logic                 hit;
    logic [LAT_W-1:0]     access_latency;
    logic                 evicted;

    int                   fail_count;
    int                   pending;
    int                   items_sent;
    bit                   steady;

    // recently used accesses, reused to make hits and set conflicts
    logic [ADDR_W-1:0]    pool_addr  [POOL_SIZE];
    logic [OWNER_W-1:0]   pool_owner [POOL_SIZE];
    logic                 pool_fetch [POOL_SIZE];
    int                   pool_n;
    logic [ADDR_W-1:0]    last_addr;
    logic [OWNER_W-1:0]   last_owner;
    logic                 last_fetch;

    lru_set_assoc_cache_tags dut (.*);

    lru_tags_checker checker_i (.*);

    // clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // cycle limit
    initial
    begin
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("lru_set_assoc_cache_tags regression: fail");
        $finish;
    end

    // result side: random stalls, one long hold-off, no stalls in steady phases
    initial
    begin
        int hold_left;
        bit hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!hold_done && items_sent >= 200)
            begin
                hold_done = 1'b1;
                hold_left = 120;
            end
            if (hold_left > 0)
            begin
                out_ready <= 1'b0;
                hold_left--;
            end
            else if (steady)
            begin
                out_ready <= 1'b1;
            end
            else
            begin
                out_ready <= ($urandom_range(0, 99) >= 35);
            end
        end
    end

    // offer one item and hold it until accepted; entered and left at a falling edge
    task automatic send_access(input logic [ADDR_W-1:0] addr, input logic [OWNER_W-1:0] owner,
                               input logic fetch);
        if (!steady)
            while ($urandom_range(0, 99) < 35)
            begin
                in_valid <= 1'b0;
                @(negedge clk);
            end
        in_valid <= 1'b1;
        access_address <= addr;
        owner_id <= owner;
        is_fetch <= fetch;
        @(posedge clk);
        while (!(in_valid && in_ready))
            @(posedge clk);
        @(negedge clk);
        last_addr = addr;
        last_owner = owner;
        last_fetch = fetch;
        items_sent++;
    endtask

    // stop offering and let every predicted result drain
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // register write: setup cycle and access cycle, then the bus is released
    task automatic write_reg(input logic [1:0] idx, input int value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= PADDR_W'({idx, 2'b00});
        pwdata <= PDATA_W'(value);
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge clk);
    endtask

    // mostly repeats and same-set tags from the pool, some fully random noise
    task automatic send_random(input int count);
        int pick;
        int j;
        logic [ADDR_W-1:0]  a;
        logic [OWNER_W-1:0] o;
        logic               f;
        repeat (count)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 15)
            begin
                a = last_addr;
                o = last_owner;
                f = last_fetch;
            end
            else if (pick < 60 && pool_n > 0)
            begin
                j = $urandom_range(0, pool_n - 1);
                a = pool_addr[j];
                o = pool_owner[j];
                f = pool_fetch[j];
            end
            else
            begin
                if (pick < 85 && pool_n > 0)
                begin
                    // new tag in the same low bits, so usually the same set
                    j = $urandom_range(0, pool_n - 1);
                    a = {16'($urandom), pool_addr[j][15:0]};
                end
                else
                begin
                    a = $urandom;
                end
                o = 4'($urandom);
                f = 1'($urandom);
                if (pool_n < POOL_SIZE)
                begin
                    j = pool_n;
                    pool_n++;
                end
                else
                begin
                    j = $urandom_range(0, POOL_SIZE - 1);
                end
                pool_addr[j] = a;
                pool_owner[j] = o;
                pool_fetch[j] = f;
            end
            send_access(a, o, f);
        end
    endtask

    task automatic run_phase(input int bsl, input int ways, input int lat, input int count,
                             input bit quiet);
        wait_idle();
        write_reg(REG_BLOCK_SIZE_LOG2, bsl);
        write_reg(REG_WAYS_IN_USE, ways);
        write_reg(REG_MISS_LATENCY, lat);
        steady = quiet;
        send_random(count);
    endtask

    // stimulus and verdict
    initial
    begin
        int k;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_valid = 1'b0;
        access_address = '0;
        owner_id = '0;
        is_fetch = 1'b0;
        steady = 1'b0;
        items_sent = 0;
        pool_n = 0;
        last_addr = '0;
        last_owner = '0;
        last_fetch = 1'b0;
        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // miss then hit, field extremes, match ignores the fetch flag
        send_access(32'h0000_0000, 4'd0, 1'b0);
        send_access(32'h0000_0000, 4'd0, 1'b0);
        send_access(32'hFFFF_FFFF, 4'd15, 1'b1);
        send_access(32'hFFFF_FFFF, 4'd15, 1'b1);
        send_access(32'hFFFF_FFFF, 4'd15, 1'b0);
        // same address, other owner: miss
        send_access(32'h0000_0000, 4'd1, 1'b0);
        // fill set 0 past its ways, then bring back the evicted entry
        for (k = 1; k <= 7; k++)
            send_access(ADDR_W'(k << 12), 4'd0, 1'b0);
        send_access(32'h0000_0000, 4'd0, 1'b0);

        // ways lowered under a full set: a miss evicts only one entry
        wait_idle();
        write_reg(REG_WAYS_IN_USE, 2);
        send_access(32'h0000_8000, 4'd0, 1'b0);
        send_access(32'h0000_9000, 4'd2, 1'b1);
        send_access(32'h0000_9000, 4'd2, 1'b1);

        // random phases over the register settings, extremes included
        run_phase(6, 8, 20, 300, 1'b0);
        run_phase(2, 4, 1023, 130, 1'b0);
        run_phase(0, 1, 0, 120, 1'b0);
        run_phase(1, 0, 1, 120, 1'b0);
        run_phase(4, 2, 33, 140, 1'b1);
        run_phase(12, 15, 7, 120, 1'b0);
        run_phase(15, 3, 500, 120, 1'b0);
        run_phase(9, 8, 1, 120, 1'b0);

        wait_idle();
        repeat (8) @(negedge clk);
        if (fail_count == 0)
            $display("lru_set_assoc_cache_tags regression: pass");
        else
            $display("lru_set_assoc_cache_tags regression: fail");
        $finish;
    end

endmodule
